// ===== sv/rlfe_pkg.sv =====
// ----------------------------------------------------------------------------
// rlfe_pkg
// Shared types and constants for the RGB linear fade engine: default widths,
// operation codes, lane sequencer states and the lane command bundle.
// ----------------------------------------------------------------------------
package rlfe_pkg;

	// default widths
	localparam int LEVEL_BITS_DEF = 8;
	localparam int TIME_BITS_DEF  = 32;

	// number of color lanes (red, green, blue)
	localparam int CHANNELS = 3;

	// operation codes carried by the input beat
	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// per-lane sequencer: multiply, divide, then fold into the level
	typedef enum logic [1:0] {
		LANE_IDLE,
		LANE_MUL,
		LANE_DIV,
		LANE_FIN
	} lane_state_t;

	// command from the top level to every lane
	typedef struct packed {
		logic set;   // new goal offered (RGB set beat)
		logic tick;  // time update
	} lane_cmd_t;

endpackage

// ===== sv/rgb_linear_fade_engine.sv =====
// ----------------------------------------------------------------------------
// rgb_linear_fade_engine
// Three-lane linear color fader with a shared output register.
// ----------------------------------------------------------------------------
// One item is in work at a time. A set beat, and a tick on which no lane has
// its end time after the tick time or the fade duration is zero, is loaded
// into the output register without lane work. On a tick that lands inside a
// ramp, each lane that is still ramping forms (goal - start) * elapsed with a
// shift-add multiplier, one bit of the level step per cycle, then divides by
// the fade duration with a restoring divider, one quotient bit per cycle;
// the lanes that ramp run in lockstep. The result sits in an output register,
// so a new beat is taken while it waits. The fade duration register may be
// written at any time the block is idle.
// ----------------------------------------------------------------------------
module rgb_linear_fade_engine #(
	parameter int LEVEL_BITS = rlfe_pkg::LEVEL_BITS_DEF,
	parameter int TIME_BITS  = rlfe_pkg::TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [TIME_BITS-1:0]  cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [TIME_BITS-1:0]  now_time,
	input  logic                  color_is_rgb,
	input  logic [LEVEL_BITS-1:0] target_red,
	input  logic [LEVEL_BITS-1:0] target_green,
	input  logic [LEVEL_BITS-1:0] target_blue,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LEVEL_BITS-1:0] red_level,
	output logic [LEVEL_BITS-1:0] green_level,
	output logic [LEVEL_BITS-1:0] blue_level
);

	logic [TIME_BITS-1:0]  fade_q;
	logic                  pend_q;
	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] red_q, green_q, blue_q;

	logic                  in_fire;
	logic                  load;
	logic                  lanes_busy;
	rlfe_pkg::lane_cmd_t   cmd;
	logic [LEVEL_BITS-1:0] tgt [rlfe_pkg::CHANNELS];
	logic [LEVEL_BITS-1:0] lvl [rlfe_pkg::CHANNELS];
	logic [rlfe_pkg::CHANNELS-1:0] busy;

	assign cfg_ready = 1'b1;
	assign in_ready  = !pend_q;
	assign in_fire   = in_valid && in_ready;

	// decode the beat into a lane command
	always_comb begin
		cmd.set  = in_fire && (operation == rlfe_pkg::OP_SET) && color_is_rgb;
		cmd.tick = in_fire && (operation == rlfe_pkg::OP_TICK);
		tgt[0]   = target_red;
		tgt[1]   = target_green;
		tgt[2]   = target_blue;
	end

	// hold the fade duration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			fade_q <= cfg_data;
		end
	end

	// one lane per color
	for (genvar c = 0; c < rlfe_pkg::CHANNELS; c++) begin : g_lane
		rlfe_lane #(
			.LEVEL_BITS (LEVEL_BITS),
			.TIME_BITS  (TIME_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.now_time (now_time),
			.duration (fade_q),
			.target   (tgt[c]),
			.level    (lvl[c]),
			.busy     (busy[c])
		);
	end

	// merge: load all three levels once every lane is done and the slot is free
	assign lanes_busy = |busy;
	assign load       = pend_q && !lanes_busy && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			red_q   <= lvl[0];
			green_q <= lvl[1];
			blue_q  <= lvl[2];
		end
	end

	assign out_valid   = out_valid_q;
	assign red_level   = red_q;
	assign green_level = green_q;
	assign blue_level  = blue_q;

endmodule

// ===== sv/rlfe_lane.sv =====
// ----------------------------------------------------------------------------
// rlfe_lane
// One color channel: holds start, goal, present level and end time, applies
// set beats at once and runs the ramp formula on a tick inside a ramp with a
// shift-add multiplier followed by a restoring divider.
// ----------------------------------------------------------------------------
module rlfe_lane #(
	parameter int LEVEL_BITS = rlfe_pkg::LEVEL_BITS_DEF,
	parameter int TIME_BITS  = rlfe_pkg::TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rlfe_pkg::lane_cmd_t   cmd,
	input  logic [TIME_BITS-1:0]  now_time,
	input  logic [TIME_BITS-1:0]  duration,
	input  logic [LEVEL_BITS-1:0] target,
	output logic [LEVEL_BITS-1:0] level,
	output logic                  busy
);

	localparam int PROD_BITS = LEVEL_BITS + TIME_BITS;
	localparam int SUM_BITS  = PROD_BITS + 2;
	localparam int CNT_BITS  = $clog2(PROD_BITS);

	rlfe_pkg::lane_state_t state_q, state_nx;

	logic [LEVEL_BITS-1:0] start_q, goal_q, level_q;
	logic [TIME_BITS-1:0]  end_q;
	logic [LEVEL_BITS-1:0] dmag_q;
	logic [TIME_BITS-1:0]  emag_q;
	logic                  neg_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic [TIME_BITS:0]    rem_q;
	logic [CNT_BITS-1:0]   cnt_q;

	logic                  finish_now;
	logic [LEVEL_BITS:0]   diff;
	logic [LEVEL_BITS-1:0] diff_mag;
	logic [TIME_BITS-1:0]  left;
	logic [TIME_BITS:0]    elapsed;
	logic [TIME_BITS:0]    elapsed_neg;
	logic [PROD_BITS-1:0]  mul_add, prod_mul;
	logic [TIME_BITS:0]    rem_sh, rem_nx;
	logic                  fits;
	logic                  last_mul, last_div;
	logic [SUM_BITS-1:0]   q_ext, q_signed, lvl_sum;
	logic [LEVEL_BITS-1:0] lvl_clamp;

	// ramp setup: remaining time, elapsed time and level step
	always_comb begin
		finish_now  = (end_q <= now_time) || (duration == '0);
		diff        = {1'b0, goal_q} - {1'b0, start_q};
		diff_mag    = diff[LEVEL_BITS] ? LEVEL_BITS'(-diff) : diff[LEVEL_BITS-1:0];
		left        = end_q - now_time;
		elapsed     = {1'b0, duration} - {1'b0, left};
		elapsed_neg = -elapsed;
	end

	// one multiplier bit and one quotient bit per cycle
	always_comb begin
		mul_add  = dmag_q[LEVEL_BITS-1] ? {{LEVEL_BITS{1'b0}}, emag_q} : '0;
		prod_mul = {prod_q[PROD_BITS-2:0], 1'b0} + mul_add;
		rem_sh   = {rem_q[TIME_BITS-1:0], prod_q[PROD_BITS-1]};
		fits     = rem_sh >= {1'b0, duration};
		rem_nx   = fits ? (rem_sh - {1'b0, duration}) : rem_sh;
		last_mul = cnt_q == CNT_BITS'(LEVEL_BITS - 1);
		last_div = cnt_q == CNT_BITS'(PROD_BITS - 1);
	end

	// apply sign, add to start and saturate
	always_comb begin
		q_ext    = {2'b00, prod_q};
		q_signed = neg_q ? -q_ext : q_ext;
		lvl_sum  = q_signed + {{(SUM_BITS - LEVEL_BITS){1'b0}}, start_q};
		if (lvl_sum[SUM_BITS-1]) begin
			lvl_clamp = '0;
		end else if (lvl_sum[SUM_BITS-2:LEVEL_BITS] != '0) begin
			lvl_clamp = '1;
		end else begin
			lvl_clamp = lvl_sum[LEVEL_BITS-1:0];
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rlfe_pkg::LANE_IDLE: begin
				if (cmd.tick && !finish_now) begin
					state_nx = rlfe_pkg::LANE_MUL;
				end
			end
			rlfe_pkg::LANE_MUL: begin
				if (last_mul) begin
					state_nx = rlfe_pkg::LANE_DIV;
				end
			end
			rlfe_pkg::LANE_DIV: begin
				if (last_div) begin
					state_nx = rlfe_pkg::LANE_FIN;
				end
			end
			rlfe_pkg::LANE_FIN: begin
				state_nx = rlfe_pkg::LANE_IDLE;
			end
			default: begin
				state_nx = rlfe_pkg::LANE_IDLE;
			end
		endcase
	end

	// hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlfe_pkg::LANE_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// channel state and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			goal_q  <= '0;
			level_q <= '0;
			end_q   <= '0;
			dmag_q  <= '0;
			emag_q  <= '0;
			neg_q   <= 1'b0;
			prod_q  <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				rlfe_pkg::LANE_IDLE: begin
					if (cmd.set && (goal_q != target)) begin
						start_q <= level_q;
						goal_q  <= target;
						end_q   <= now_time + duration;
					end
					if (cmd.tick) begin
						if (finish_now) begin
							level_q <= goal_q;
						end else begin
							dmag_q <= diff_mag;
							emag_q <= elapsed[TIME_BITS] ? elapsed_neg[TIME_BITS-1:0]
							                             : elapsed[TIME_BITS-1:0];
							neg_q  <= diff[LEVEL_BITS] ^ elapsed[TIME_BITS];
							prod_q <= '0;
							rem_q  <= '0;
							cnt_q  <= '0;
						end
					end
				end
				rlfe_pkg::LANE_MUL: begin
					prod_q <= prod_mul;
					dmag_q <= {dmag_q[LEVEL_BITS-2:0], 1'b0};
					cnt_q  <= last_mul ? '0 : cnt_q + 1'b1;
				end
				rlfe_pkg::LANE_DIV: begin
					rem_q  <= rem_nx;
					prod_q <= {prod_q[PROD_BITS-2:0], fits};
					cnt_q  <= last_div ? '0 : cnt_q + 1'b1;
				end
				rlfe_pkg::LANE_FIN: begin
					level_q <= lvl_clamp;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	assign level = level_q;
	assign busy  = state_q != rlfe_pkg::LANE_IDLE;

endmodule
